>>> rtl/lcd_parallel_window_write_sequencer_macros.svh
// ----------------------------------------------------------------------------
// LCD window write sequencer assertion macros
// Shared property forms for the checker of the sequencer's ports.
// ----------------------------------------------------------------------------
`ifndef LCD_PARALLEL_WINDOW_WRITE_SEQUENCER_MACROS_SVH
`define LCD_PARALLEL_WINDOW_WRITE_SEQUENCER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define LPW_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LPW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lpw_pkg.sv
// ----------------------------------------------------------------------------
// LCD window write sequencer package
// Types, command codes and the byte table shared by the sequencer modules.
// ----------------------------------------------------------------------------
package lpw_pkg;

    // Request kinds.
    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_WINDOW = 2'd1,
        OP_PIXEL  = 2'd2,
        OP_END    = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam logic REG_ACCESS_CTRL = 1'b0;
    localparam logic REG_PIXEL_FMT   = 1'b1;

    localparam logic [7:0] ACCESS_CTRL_RESET = 8'hA0;
    localparam logic [7:0] PIXEL_FMT_RESET   = 8'h05;

    // Display controller command codes.
    localparam logic [7:0] CMD_NOP         = 8'h00;
    localparam logic [7:0] CMD_SLEEP_OUT   = 8'h11;
    localparam logic [7:0] CMD_NORMAL_MODE = 8'h13;
    localparam logic [7:0] CMD_DISPLAY_OFF = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h29;
    localparam logic [7:0] CMD_COLUMN_SET  = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET     = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE   = 8'h2C;
    localparam logic [7:0] CMD_ACCESS_CTRL = 8'h36;
    localparam logic [7:0] CMD_PIXEL_FMT   = 8'h3A;
    localparam logic [7:0] CMD_RAM_CTRL    = 8'hB0;
    localparam logic [7:0] BYTE_ZERO       = 8'h00;

    localparam int unsigned IDX_W = 4;

    // A request held for sequencing, with its end coordinates worked out.
    typedef struct packed {
        op_t         op;
        logic [15:0] x_start;
        logic [15:0] x_end;
        logic [15:0] y_start;
        logic [15:0] y_end;
        logic [15:0] pixel_color;
    } item_t;

    // One bus beat.
    typedef struct packed {
        logic       last_of_run;
        logic       release_select;
        logic       is_data;
        logic [7:0] bus_byte;
    } beat_t;

    // Byte number idx of the sequence that request it causes.
    function automatic beat_t seq_beat(item_t it, logic [IDX_W-1:0] idx,
                                       logic [7:0] acv, logic [7:0] pfv);
        beat_t b;
        b = '0;
        unique case (it.op)
            OP_INIT: begin
                case (idx)
                    4'd0:    b.bus_byte = CMD_DISPLAY_OFF;
                    4'd1:    b.bus_byte = CMD_SLEEP_OUT;
                    4'd2:    b.bus_byte = CMD_NORMAL_MODE;
                    4'd3:    b.bus_byte = CMD_ACCESS_CTRL;
                    4'd4:    begin b.bus_byte = acv;       b.is_data = 1'b1; end
                    4'd5:    b.bus_byte = CMD_RAM_CTRL;
                    4'd6:    begin b.bus_byte = BYTE_ZERO; b.is_data = 1'b1; end
                    4'd7:    begin b.bus_byte = BYTE_ZERO; b.is_data = 1'b1; end
                    4'd8:    b.bus_byte = CMD_PIXEL_FMT;
                    4'd9:    begin b.bus_byte = pfv;       b.is_data = 1'b1; end
                    default: begin
                        b.bus_byte       = CMD_DISPLAY_ON;
                        b.release_select = 1'b1;
                        b.last_of_run    = 1'b1;
                    end
                endcase
            end
            OP_WINDOW: begin
                b.is_data = 1'b1;
                case (idx)
                    4'd0:    begin b.bus_byte = CMD_COLUMN_SET; b.is_data = 1'b0; end
                    4'd1:    b.bus_byte = it.x_start[15:8];
                    4'd2:    b.bus_byte = it.x_start[7:0];
                    4'd3:    b.bus_byte = it.x_end[15:8];
                    4'd4:    b.bus_byte = it.x_end[7:0];
                    4'd5:    begin b.bus_byte = CMD_ROW_SET; b.is_data = 1'b0; end
                    4'd6:    b.bus_byte = it.y_start[15:8];
                    4'd7:    b.bus_byte = it.y_start[7:0];
                    4'd8:    b.bus_byte = it.y_end[15:8];
                    4'd9:    b.bus_byte = it.y_end[7:0];
                    default: begin
                        b.bus_byte    = CMD_MEM_WRITE;
                        b.is_data     = 1'b0;
                        b.last_of_run = 1'b1;
                    end
                endcase
            end
            OP_PIXEL: begin
                b.is_data = 1'b1;
                if (idx == '0) begin
                    b.bus_byte = it.pixel_color[15:8];
                end else begin
                    b.bus_byte    = it.pixel_color[7:0];
                    b.last_of_run = 1'b1;
                end
            end
            OP_END: begin
                b.bus_byte       = CMD_NOP;
                b.release_select = 1'b1;
                b.last_of_run    = 1'b1;
            end
        endcase
        return b;
    endfunction

endpackage

>>> rtl/lpw_in_stage.sv
// ----------------------------------------------------------------------------
// LCD window write sequencer input stage
// Registers an accepted request and works out the window end coordinates.
// ----------------------------------------------------------------------------
module lpw_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      in_op,
    input  logic [15:0]     in_x_start,
    input  logic [15:0]     in_y_start,
    input  logic [15:0]     in_win_width,
    input  logic [15:0]     in_win_height,
    input  logic [15:0]     in_pixel_color,
    output logic            item_valid,
    input  logic            item_ready,
    output lpw_pkg::item_t  item
);
    import lpw_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  take;

    assign in_ready   = !valid_reg || item_ready;
    assign take       = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // The end coordinate is start plus size minus one, wrapping at 16 bits.
    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take) begin
            valid_next            = 1'b1;
            item_next.op          = op_t'(in_op);
            item_next.x_start     = in_x_start;
            item_next.x_end       = 16'(in_x_start + in_win_width - 16'd1);
            item_next.y_start     = in_y_start;
            item_next.y_end       = 16'(in_y_start + in_win_height - 16'd1);
            item_next.pixel_color = in_pixel_color;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

>>> rtl/lpw_byte_seq.sv
// ----------------------------------------------------------------------------
// LCD window write sequencer byte stage
// Steps through the bytes of the held request into the output register, one beat
// a cycle while that register has room.
// ----------------------------------------------------------------------------
module lpw_byte_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      access_ctrl,
    input  logic [7:0]      pixel_fmt,
    input  logic            item_valid,
    output logic            item_ready,
    input  lpw_pkg::item_t  item,
    output logic            out_valid,
    input  logic            out_ready,
    output lpw_pkg::beat_t  out_beat
);
    import lpw_pkg::*;

    item_t            cur_reg, cur_next;
    logic             cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    beat_t            out_reg, out_next;
    beat_t            beat;
    logic             out_free;
    logic             advance;
    logic             finish;

    assign beat       = seq_beat(cur_reg, idx_reg, access_ctrl, pixel_fmt);
    assign out_free   = !out_valid_reg || out_ready;
    assign advance    = cur_valid_reg && out_free;
    assign finish     = advance && beat.last_of_run;
    assign item_ready = !cur_valid_reg || finish;
    assign out_valid  = out_valid_reg;
    assign out_beat   = out_reg;

    // Move one beat to the output register whenever it has room; load the
    // next request as the last beat of the current one leaves.
    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance) begin
            out_next       = beat;
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        if (item_ready) begin
            cur_next       = item;
            cur_valid_next = item_valid;
            idx_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

endmodule

>>> rtl/lcd_parallel_window_write_sequencer.sv
// ----------------------------------------------------------------------------
// LCD parallel window write sequencer
// Turns display requests into byte beats for an 8-bit 8080-style LCD bus.
// ----------------------------------------------------------------------------
// Channel | Direction | Beat
// s_      | in        | one request: kind in tuser, coordinates and colour
// m_      | out       | one bus byte with data/command and release flags
// cfg_    | in        | register write, taken in the cycle it is presented
//
// A request has as many bus bytes as its kind gives: pixel 2, end 1, init and
// window 11. From acceptance a request passes the input register, the byte
// stage's held-request register, then the output register. The byte stage
// sets the rate.
// Reset clears the valid flags and reloads both registers to their defaults.
// A stalled output holds its beat; the input register can hold one request while
// the byte stage still works on the one before.
// ----------------------------------------------------------------------------
module lcd_parallel_window_write_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x_start [15:0], y_start [31:16], win_width [47:32], win_height [63:48],
    // pixel_color [79:64]
    input  logic [79:0] s_tdata,
    // op [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bus_byte [7:0]
    output logic [7:0]  m_tdata,
    // is_data [0], release_select [1]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [7:0]  cfg_wr_data
);
    import lpw_pkg::*;

    logic [7:0] access_ctrl_reg, access_ctrl_next;
    logic [7:0] pixel_fmt_reg, pixel_fmt_next;
    logic       item_valid;
    logic       item_ready;
    item_t      item;
    beat_t      out_beat;

    // Configuration register writes.
    always_comb begin
        access_ctrl_next = access_ctrl_reg;
        pixel_fmt_next   = pixel_fmt_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_ACCESS_CTRL: access_ctrl_next = cfg_wr_data;
                REG_PIXEL_FMT:   pixel_fmt_next   = cfg_wr_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            access_ctrl_reg <= ACCESS_CTRL_RESET;
            pixel_fmt_reg   <= PIXEL_FMT_RESET;
        end else begin
            access_ctrl_reg <= access_ctrl_next;
            pixel_fmt_reg   <= pixel_fmt_next;
        end
    end

    // Input register.
    lpw_in_stage u_in_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_op          (s_tuser),
        .in_x_start     (s_tdata[15:0]),
        .in_y_start     (s_tdata[31:16]),
        .in_win_width   (s_tdata[47:32]),
        .in_win_height  (s_tdata[63:48]),
        .in_pixel_color (s_tdata[79:64]),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item)
    );

    // Byte stepping and output register.
    lpw_byte_seq u_byte_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .access_ctrl (access_ctrl_reg),
        .pixel_fmt   (pixel_fmt_reg),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_beat    (out_beat)
    );

    assign m_tdata = out_beat.bus_byte;
    assign m_tuser = {out_beat.release_select, out_beat.is_data};
    assign m_tlast = out_beat.last_of_run;

endmodule

>>> rtl/lpw_port_checker.sv
// ----------------------------------------------------------------------------
// LCD window write sequencer port checker
// Watches the result channel of the sequencer over time.
// ----------------------------------------------------------------------------
`include "lcd_parallel_window_write_sequencer_macros.svh"

module lpw_port_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A stalled beat stays offered.
    `LPW_ASSERT_NEXT(a_valid_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "beat withdrawn while stalled")

    // A stalled beat keeps its byte.
    `LPW_ASSERT_NEXT(a_byte_holds, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "byte changed while stalled")

    // Chip select is released only with the final byte of a request.
    `LPW_ASSERT_SAME(a_release_last, aclk, aresetn, m_tvalid && m_tuser[1], m_tlast, "release before end of request")

    // A byte that releases chip select is always a command.
    `LPW_ASSERT_SAME(a_release_cmd, aclk, aresetn, m_tvalid && m_tuser[1], !m_tuser[0], "release on a data byte")

endmodule

bind lcd_parallel_window_write_sequencer lpw_port_checker u_lpw_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD parallel window write sequencer testbench
// Sends init, window, pixel and end requests on the request stream and checks
// every bus byte beat against a sequence predicted from the request and the
// two init registers. Both stream sides pause in random bursts, and the init
// registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import lpw_pkg::*;

    localparam int unsigned RUN_LIMIT_NS = 5_000_000;

    // Predicts the bus byte beats of each accepted request and checks the
    // beats leaving the block against them in order.
    class lcd_byte_scoreboard;
        logic [7:0]  access_ctrl;
        logic [7:0]  pixel_fmt;
        beat_t       beats_due[$];
        int unsigned mismatches;
        int unsigned beats_checked;
        int unsigned register_writes;
        int unsigned requests_by_kind[4];

        function new();
            access_ctrl = ACCESS_CTRL_RESET;
            pixel_fmt   = PIXEL_FMT_RESET;
        endfunction

        function int unsigned pending();
            return beats_due.size();
        endfunction

        function void set_register(logic index, logic [7:0] value);
            register_writes++;
            if (index == REG_ACCESS_CTRL) begin
                access_ctrl = value;
            end else begin
                pixel_fmt = value;
            end
        endfunction

        function void push_beat(logic [7:0] value, logic is_data, logic closing,
                                logic release_cs);
            beat_t b;
            b.bus_byte       = value;
            b.is_data        = is_data;
            b.last_of_run    = closing;
            b.release_select = release_cs;
            beats_due.push_back(b);
        endfunction

        // A coordinate goes out as two parameter bytes, high byte first.
        function void push_word(logic [15:0] value, logic closing);
            push_beat(value[15:8], 1'b1, 1'b0, 1'b0);
            push_beat(value[7:0], 1'b1, closing, 1'b0);
        endfunction

        function void note_request(op_t kind, logic [15:0] x0, logic [15:0] y0,
                                   logic [15:0] w, logic [15:0] h,
                                   logic [15:0] colour);
            logic [15:0] x1;
            logic [15:0] y1;
            // End coordinates wrap within 16 bits, so a zero size gives start-1.
            x1 = x0 + w - 16'd1;
            y1 = y0 + h - 16'd1;
            requests_by_kind[int'(kind)]++;
            case (kind)
                OP_INIT: begin
                    push_beat(CMD_DISPLAY_OFF, 1'b0, 1'b0, 1'b0);
                    push_beat(CMD_SLEEP_OUT, 1'b0, 1'b0, 1'b0);
                    push_beat(CMD_NORMAL_MODE, 1'b0, 1'b0, 1'b0);
                    push_beat(CMD_ACCESS_CTRL, 1'b0, 1'b0, 1'b0);
                    push_beat(access_ctrl, 1'b1, 1'b0, 1'b0);
                    push_beat(CMD_RAM_CTRL, 1'b0, 1'b0, 1'b0);
                    push_beat(BYTE_ZERO, 1'b1, 1'b0, 1'b0);
                    push_beat(BYTE_ZERO, 1'b1, 1'b0, 1'b0);
                    push_beat(CMD_PIXEL_FMT, 1'b0, 1'b0, 1'b0);
                    push_beat(pixel_fmt, 1'b1, 1'b0, 1'b0);
                    push_beat(CMD_DISPLAY_ON, 1'b0, 1'b1, 1'b1);
                end
                OP_WINDOW: begin
                    push_beat(CMD_COLUMN_SET, 1'b0, 1'b0, 1'b0);
                    push_word(x0, 1'b0);
                    push_word(x1, 1'b0);
                    push_beat(CMD_ROW_SET, 1'b0, 1'b0, 1'b0);
                    push_word(y0, 1'b0);
                    push_word(y1, 1'b0);
                    push_beat(CMD_MEM_WRITE, 1'b0, 1'b1, 1'b0);
                end
                OP_PIXEL: begin
                    push_word(colour, 1'b1);
                end
                default: begin
                    push_beat(CMD_NOP, 1'b0, 1'b1, 1'b1);
                end
            endcase
        endfunction

        task report(string what);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        task check_beat(logic [7:0] value, logic [1:0] flags, logic last_flag);
            beat_t b;
            if (beats_due.size() == 0) begin
                report($sformatf("unexpected beat byte %02h flags %b last %b",
                                 value, flags, last_flag));
                return;
            end
            b = beats_due.pop_front();
            beats_checked++;
            if (value !== b.bus_byte)
                report($sformatf("bus_byte %02h, expected %02h", value, b.bus_byte));
            if (flags[0] !== b.is_data)
                report($sformatf("is_data %b, expected %b (byte %02h)",
                                 flags[0], b.is_data, b.bus_byte));
            if (flags[1] !== b.release_select)
                report($sformatf("release_select %b, expected %b (byte %02h)",
                                 flags[1], b.release_select, b.bus_byte));
            if (last_flag !== b.last_of_run)
                report($sformatf("last_of_run %b, expected %b (byte %02h)",
                                 last_flag, b.last_of_run, b.bus_byte));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic        cfg_wr_index;
    logic [7:0]  cfg_wr_data;

    // Set for the closing stretch, where neither side pauses.
    bit quiet_tail = 1'b0;

    lcd_byte_scoreboard sb = new();

    lcd_parallel_window_write_sequencer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // 20 ns clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watch register writes, accepted requests and delivered beats at the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                sb.set_register(cfg_wr_index, cfg_wr_data);
            if (s_tvalid && s_tready)
                sb.note_request(op_t'(s_tuser), s_tdata[15:0], s_tdata[31:16],
                                s_tdata[47:32], s_tdata[63:48], s_tdata[79:64]);
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata, m_tuser, m_tlast);
        end
    end

    // Receiver: ready runs broken by random stall bursts.
    initial begin
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
        end
    end

    // Mostly random 16-bit values, with the extremes weighted up.
    function automatic logic [15:0] rand_word();
        logic [15:0] w;
        w = 16'($urandom());
        case ($urandom_range(0, 7))
            0:       w = 16'h0000;
            1:       w = 16'hFFFF;
            default: ;
        endcase
        return w;
    endfunction

    // Present one request, possibly after a short gap, and hold it until taken.
    task automatic send_request(op_t kind, logic [15:0] x0, logic [15:0] y0,
                                logic [15:0] w, logic [15:0] h,
                                logic [15:0] colour);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {colour, h, w, y0, x0};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random(op_t kind);
        send_request(kind, rand_word(), rand_word(), rand_word(), rand_word(),
                     rand_word());
    endtask

    // Stop sending and wait until every predicted beat has been delivered.
    task automatic hold_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(logic index, logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= value;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    // Mostly well-formed display updates (optional init, window, pixel burst,
    // end) with some requests of any kind thrown in between.
    task automatic run_traffic(int unsigned quota);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 5) == 0) begin
                send_random(op_t'($urandom_range(0, 3)));
                sent++;
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    send_random(OP_INIT);
                    sent++;
                end
                send_random(OP_WINDOW);
                burst = $urandom_range(1, 12);
                repeat (burst) send_random(OP_PIXEL);
                sent += burst + 1;
                if ($urandom_range(0, 2) != 0) begin
                    send_random(OP_END);
                    sent++;
                end
            end
        end
    endtask

    // Main sequence.
    initial begin
        int unsigned phase_no;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_INIT;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = REG_ACCESS_CTRL;
        cfg_wr_data  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests with the registers at their reset values.
        send_random(OP_INIT);
        send_request(OP_WINDOW, 16'h0000, 16'h0000, 16'h0000, 16'h0000, rand_word());
        send_request(OP_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, rand_word());
        send_request(OP_WINDOW, 16'h00FF, 16'hFF00, 16'h0100, 16'h0001, rand_word());
        send_request(OP_WINDOW, 16'hAAAA, 16'h5555, 16'h5556, 16'hAAAB, rand_word());
        send_request(OP_PIXEL, rand_word(), rand_word(), rand_word(), rand_word(),
                     16'h0000);
        send_request(OP_PIXEL, rand_word(), rand_word(), rand_word(), rand_word(),
                     16'hFFFF);
        send_request(OP_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
        send_request(OP_PIXEL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFF00);
        send_request(OP_PIXEL, rand_word(), rand_word(), rand_word(), rand_word(),
                     16'hA55A);
        send_random(OP_END);
        send_request(OP_INIT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_END, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Register extremes, each followed by an init that shows them.
        hold_until_drained();
        write_register(REG_ACCESS_CTRL, 8'h00);
        write_register(REG_PIXEL_FMT, 8'h00);
        send_random(OP_INIT);
        hold_until_drained();
        write_register(REG_ACCESS_CTRL, 8'hFF);
        write_register(REG_PIXEL_FMT, 8'hFF);
        send_random(OP_INIT);
        send_random(OP_END);

        // Random phases, each under its own register setting.
        for (phase_no = 0; phase_no < 6; phase_no++) begin
            hold_until_drained();
            case (phase_no)
                0: begin
                    write_register(REG_ACCESS_CTRL, 8'hFF);
                    write_register(REG_PIXEL_FMT, 8'h00);
                end
                1: begin
                    write_register(REG_ACCESS_CTRL, 8'h00);
                    write_register(REG_PIXEL_FMT, 8'hFF);
                end
                default: begin
                    write_register(REG_ACCESS_CTRL, 8'($urandom()));
                    write_register(REG_PIXEL_FMT, 8'($urandom()));
                end
            endcase
            run_traffic(35);
        end

        // Closing stretch at full rate with the reset settings back in place.
        hold_until_drained();
        write_register(REG_ACCESS_CTRL, ACCESS_CTRL_RESET);
        write_register(REG_PIXEL_FMT, PIXEL_FMT_RESET);
        quiet_tail = 1'b1;
        run_traffic(40);

        hold_until_drained();
        repeat (10) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d beats never delivered", sb.pending()));

        $display("Sent %0d init, %0d window, %0d pixel and %0d end requests;",
                 sb.requests_by_kind[0], sb.requests_by_kind[1],
                 sb.requests_by_kind[2], sb.requests_by_kind[3]);
        $display("checked %0d bus beats across %0d register writes, %0d mismatches.",
                 sb.beats_checked, sb.register_writes, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("PASS lcd_parallel_window_write_sequencer");
        end else begin
            $display("FAIL lcd_parallel_window_write_sequencer");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timed out with %0d beats outstanding.", sb.pending());
        $display("FAIL lcd_parallel_window_write_sequencer");
        $finish;
    end

endmodule
